// ===== design/mtt_pkg.sv =====
package mtt_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int OP_W   = 3;
    localparam int ID_W   = 5;
    localparam int MODE_W = 2;
    localparam int CNT_W  = 32;
    localparam int ST_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;
    localparam logic [OP_W-1:0] OP_SERVICE = 3'd5;

    // timer modes
    localparam logic [MODE_W-1:0] MODE_ONE_DELETE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONE_KEEP   = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_EXIST = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [ST_W-1:0] ST_NO_FREE   = 2'd3;

    typedef enum logic [1:0] {
        RS_STOPPED = 2'd0,
        RS_RUNNING = 2'd1,
        RS_EXPIRED = 2'd2
    } t_run;

    // slot update produced by the shared unit
    typedef struct packed {
        logic             act;
        logic             keep;
        t_run             run;
        logic             cnt_we;
        logic [CNT_W-1:0] cnt;
        logic             fire;
    } t_upd;

endpackage

// ===== design/mtt_ifs.sv =====
interface mtt_in_if import mtt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   timer_id;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  period;

    modport source (output valid, operation, timer_id, mode, period, input ready);
    modport sink   (input valid, operation, timer_id, mode, period, output ready);
endinterface

interface mtt_out_if import mtt_pkg::*;;
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] result_id;
    logic            fired;
    logic            last;

    modport source (output valid, status, result_id, fired, last, input ready);
    modport sink   (input valid, status, result_id, fired, last, output ready);
endinterface

// ===== design/multi_timer_table.sv =====
// multi_timer_table holds NUM_TIMERS software timers addressed as slots
// 1..NUM_TIMERS. Create, start, stop, delete and undefined operations load
// their result from the decode state, which waits until the output register
// can take it. Tick and service walk the table one slot per cycle through one
// read port and one write port on the count, period and mode store and one
// shared slot update unit; a tick stalls its last slot until its result can
// be handed over, and a service ends early after its last fired timer and
// stalls a slot whenever a fired result cannot be handed over. The input is
// not ready while an item is being worked; the output register lets the next
// item enter while the final result still waits to be taken. Slot valid and
// run state reset cleared, so no clearing pass is needed after reset.
module multi_timer_table import mtt_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    mtt_in_if.sink    i_in,
    mtt_out_if.source o_out
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_WALK   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    // captured transaction
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_per;

    // per-slot control state, cleared by reset
    logic [NUM_TIMERS-1:0] r_valid;
    t_run                  r_run [NUM_TIMERS];

    // output register
    logic            r_ov;
    logic [ST_W-1:0] r_status;
    logic [ID_W-1:0] r_rid;
    logic            r_fired;
    logic            r_last;

    logic in_acc;
    logic out_free;

    logic [NUM_TIMERS-1:0] run_mask;
    logic [NUM_TIMERS-1:0] exp_mask;
    logic [NUM_TIMERS-1:0] hi_mask;

    logic          free_any;
    logic [IW-1:0] free_idx;
    logic [IW:0]   free_p1;
    logic [IW:0]   idx_p1;
    logic [6:0]    id_m1;
    logic [IW-1:0] id_slot;
    logic          id_bad;

    logic is_tick;
    logic at_last;
    logic need_out;
    logic adv;

    // result being loaded this cycle
    logic            emit;
    logic [ST_W-1:0] e_status;
    logic [ID_W-1:0] e_id;
    logic            e_fired;
    logic            e_last;

    // slot control update
    logic          upd_en;
    logic [IW-1:0] upd_slot;
    logic          upd_valid;
    t_run          upd_run;

    // store access
    logic [IW-1:0]     wr_addr;
    logic              wr_cfg;
    logic              wr_cnt_we;
    logic [CNT_W-1:0]  wr_cnt;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  rd_per;
    logic [MODE_W-1:0] rd_mode;

    t_upd upd;

    // handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;

    assign o_out.valid     = r_ov;
    assign o_out.status    = r_status;
    assign o_out.result_id = r_rid;
    assign o_out.fired     = r_fired;
    assign o_out.last      = r_last;

    // slot flags; hi_mask marks expired slots past the one being walked
    for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_slot
        assign run_mask[j] = r_valid[j] && (r_run[j] == RS_RUNNING);
        assign exp_mask[j] = r_valid[j] && (r_run[j] == RS_EXPIRED);
        assign hi_mask[j]  = exp_mask[j] && (j > int'(r_idx));
    end

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    assign free_p1 = {1'b0, free_idx} + (IW + 1)'(1);
    assign idx_p1  = {1'b0, r_idx} + (IW + 1)'(1);

    // identifier range check comes before the lookup
    assign id_bad  = (r_id == '0) || (int'(r_id) > NUM_TIMERS);
    assign id_m1   = 7'(r_id) - 7'd1;
    assign id_slot = id_m1[IW-1:0];

    assign is_tick  = (r_op == OP_TICK);
    assign at_last  = (r_idx == LAST_IDX);
    assign need_out = is_tick ? at_last : exp_mask[r_idx];
    assign adv      = !need_out || out_free;

    mtt_slot_alu u_alu (
        .i_tick    (is_tick),
        .i_running (run_mask[r_idx]),
        .i_expired (exp_mask[r_idx]),
        .i_mode    (rd_mode),
        .i_cnt     (rd_cnt),
        .i_per     (rd_per),
        .o_upd     (upd)
    );

    mtt_store #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_addr   (wr_addr),
        .i_wr_cfg    (wr_cfg),
        .i_wr_cnt_we (wr_cnt_we),
        .i_wr_cnt    (wr_cnt),
        .i_wr_mode   (r_mode),
        .i_wr_per    (r_per),
        .i_rd_addr   (n_idx),
        .o_rd_cnt    (rd_cnt),
        .o_rd_per    (rd_per),
        .o_rd_mode   (rd_mode)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_id      = '0;
        e_fired   = 1'b0;
        e_last    = 1'b1;
        upd_en    = 1'b0;
        upd_slot  = r_idx;
        upd_valid = 1'b1;
        upd_run   = RS_STOPPED;
        wr_addr   = r_idx;
        wr_cfg    = 1'b0;
        wr_cnt_we = 1'b0;
        wr_cnt    = upd.cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    unique case (r_op) inside
                        OP_CREATE: begin
                            emit = 1'b1;
                            if (free_any) begin
                                e_id      = ID_W'(free_p1);
                                upd_en    = 1'b1;
                                upd_slot  = free_idx;
                                wr_addr   = free_idx;
                                wr_cfg    = 1'b1;
                                wr_cnt_we = 1'b1;
                                wr_cnt    = '0;
                            end else begin
                                e_status = ST_NO_FREE;
                            end
                        end
                        OP_START, OP_STOP, OP_DELETE: begin
                            emit = 1'b1;
                            if (id_bad) begin
                                e_status = ST_RANGE;
                            end else if (!r_valid[id_slot]) begin
                                e_status = ST_NOT_EXIST;
                            end else begin
                                upd_en    = 1'b1;
                                upd_slot  = id_slot;
                                upd_valid = (r_op != OP_DELETE);
                                upd_run   = (r_op == OP_START) ? RS_RUNNING : RS_STOPPED;
                            end
                        end
                        OP_TICK: begin
                            // read of slot zero issued now
                            n_idx   = '0;
                            n_state = S_WALK;
                        end
                        OP_SERVICE: begin
                            if (|exp_mask) begin
                                n_idx   = '0;
                                n_state = S_WALK;
                            end else begin
                                // empty service
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (adv) begin
                    upd_en    = upd.act;
                    upd_valid = upd.keep;
                    upd_run   = upd.run;
                    wr_cnt_we = upd.cnt_we;
                    if (is_tick) begin
                        emit = at_last;
                    end else if (need_out) begin
                        emit    = 1'b1;
                        e_id    = ID_W'(idx_p1);
                        e_fired = 1'b1;
                        e_last  = ~|hi_mask;
                    end
                    if (at_last || (emit && e_last)) begin
                        n_state = S_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // capture the input transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in.operation;
            r_id   <= i_in.timer_id;
            r_mode <= i_in.mode;
            r_per  <= i_in.period;
        end
    end

    // slot valid and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_run[k] <= RS_STOPPED;
            end
        end else if (upd_en) begin
            r_valid[upd_slot] <= upd_valid;
            r_run[upd_slot]   <= upd_run;
        end
    end

    // output register; a new result may load while the old one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= e_status;
            r_rid    <= e_id;
            r_fired  <= e_fired;
            r_last   <= e_last;
        end
    end

    // an accepted transaction always goes to decode next
    a_acc_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DECODE))
        else $error("accepted transaction did not enter decode");

    // leaving a busy state means a final result was just loaded
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ($past(r_state) != S_IDLE) && (r_state == S_IDLE))
        |-> (r_ov && r_last))
        else $error("returned to idle without a final result");

    // a fired result names a real slot with ok status
    a_fired_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_fired) |-> ((r_rid != '0) && (r_status == ST_OK)))
        else $error("fired result without slot");

    // a fired emission during the walk comes from an expired slot
    a_fire_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && e_fired) |-> ((r_state == S_WALK) && exp_mask[r_idx] && !is_tick))
        else $error("fired result from a slot that was not expired");

endmodule

// ===== design/mtt_slot_alu.sv =====
module mtt_slot_alu import mtt_pkg::*; (
    input  logic              i_tick,
    input  logic              i_running,
    input  logic              i_expired,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CNT_W-1:0]  i_cnt,
    input  logic [CNT_W-1:0]  i_per,
    output t_upd              o_upd
);

    logic [CNT_W-1:0] cnt_inc;

    // saturating increment
    assign cnt_inc = (&i_cnt) ? i_cnt : i_cnt + CNT_W'(1);

    always_comb begin
        o_upd      = '0;
        o_upd.keep = 1'b1;
        o_upd.run  = RS_STOPPED;
        if (i_tick) begin
            if (i_running) begin
                o_upd.act    = 1'b1;
                o_upd.cnt_we = 1'b1;
                o_upd.cnt    = cnt_inc;
                o_upd.run    = (cnt_inc >= i_per) ? RS_EXPIRED : RS_RUNNING;
            end
        end else if (i_expired) begin
            o_upd.fire = 1'b1;
            unique case (i_mode)
                MODE_ONE_DELETE: begin
                    o_upd.act  = 1'b1;
                    o_upd.keep = 1'b0;
                    o_upd.run  = RS_STOPPED;
                end
                MODE_LOOP: begin
                    o_upd.act    = 1'b1;
                    o_upd.cnt_we = 1'b1;
                    o_upd.run    = RS_RUNNING;
                end
                MODE_ONE_KEEP: begin
                    o_upd.act    = 1'b1;
                    o_upd.cnt_we = 1'b1;
                    o_upd.run    = RS_STOPPED;
                end
                default: begin
                    // undefined mode: stays expired
                    o_upd.act = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== design/mtt_store.sv =====
module mtt_store import mtt_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic              i_clk,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic              i_wr_cfg,
    input  logic              i_wr_cnt_we,
    input  logic [CNT_W-1:0]  i_wr_cnt,
    input  logic [MODE_W-1:0] i_wr_mode,
    input  logic [CNT_W-1:0]  i_wr_per,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [CNT_W-1:0]  o_rd_cnt,
    output logic [CNT_W-1:0]  o_rd_per,
    output logic [MODE_W-1:0] o_rd_mode
);

    logic [CNT_W-1:0]  r_cnt_mem  [NUM_TIMERS];
    logic [CNT_W-1:0]  r_per_mem  [NUM_TIMERS];
    logic [MODE_W-1:0] r_mode_mem [NUM_TIMERS];

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt_we) begin
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        if (i_wr_cfg) begin
            r_per_mem[i_wr_addr]  <= i_wr_per;
            r_mode_mem[i_wr_addr] <= i_wr_mode;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_cnt  <= r_cnt_mem[i_rd_addr];
        o_rd_per  <= r_per_mem[i_rd_addr];
        o_rd_mode <= r_mode_mem[i_rd_addr];
    end

endmodule

// ===== tb/multi_timer_table_test.sv =====
module multi_timer_table_test;
    import mtt_pkg::*;

    localparam int N           = NUM_TIMERS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 3 * (N + 2);
    localparam int PHASE_OPS   = 66;

    // codes outside the package: the fourth mode and the two spare operations
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;
    localparam logic [OP_W-1:0]   OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] slot_id;
        logic            fired;
        logic            last;
    } t_timer_result;

    // timer table mirror plus the queue of results still owed by the block
    class timer_table_board;
        bit               live [N];
        t_run             state [N];
        logic [MODE_W-1:0] tmode [N];
        logic [CNT_W-1:0] count [N];
        logic [CNT_W-1:0] limit [N];
        t_timer_result    due_results [$];
        int               errors;

        function new();
            for (int i = 0; i < N; i++) begin
                live[i]  = 1'b0;
                state[i] = RS_STOPPED;
                tmode[i] = MODE_ONE_DELETE;
                count[i] = '0;
                limit[i] = '0;
            end
            errors = 0;
        endfunction

        function void queue_result(logic [ST_W-1:0] st, int slot, bit fired, bit last);
            t_timer_result r;
            r.status  = st;
            r.slot_id = ID_W'(slot);
            r.fired   = fired;
            r.last    = last;
            due_results.push_back(r);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // advance the mirror by one accepted input transaction
        function void note_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [MODE_W-1:0] md, logic [CNT_W-1:0] per);
            int slot;
            int final_slot;
            slot       = -1;
            final_slot = -1;
            case (op)
                OP_CREATE: begin
                    for (int i = N - 1; i >= 0; i--)
                        if (!live[i])
                            slot = i;
                    if (slot < 0) begin
                        queue_result(ST_NO_FREE, 0, 1'b0, 1'b1);
                    end else begin
                        live[slot]  = 1'b1;
                        state[slot] = RS_STOPPED;
                        tmode[slot] = md;
                        count[slot] = '0;
                        limit[slot] = per;
                        queue_result(ST_OK, slot + 1, 1'b0, 1'b1);
                    end
                end
                OP_START, OP_STOP, OP_DELETE: begin
                    if (id == 0 || int'(id) > N) begin
                        queue_result(ST_RANGE, 0, 1'b0, 1'b1);
                    end else if (!live[int'(id) - 1]) begin
                        queue_result(ST_NOT_EXIST, 0, 1'b0, 1'b1);
                    end else begin
                        slot = int'(id) - 1;
                        if (op == OP_START) begin
                            state[slot] = RS_RUNNING;
                        end else if (op == OP_STOP) begin
                            state[slot] = RS_STOPPED;
                        end else begin
                            live[slot]  = 1'b0;
                            state[slot] = RS_STOPPED;
                        end
                        queue_result(ST_OK, 0, 1'b0, 1'b1);
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < N; i++) begin
                        if (live[i] && state[i] == RS_RUNNING) begin
                            if (count[i] != '1)
                                count[i] = count[i] + CNT_W'(1);
                            if (count[i] >= limit[i])
                                state[i] = RS_EXPIRED;
                        end
                    end
                    queue_result(ST_OK, 0, 1'b0, 1'b1);
                end
                OP_SERVICE: begin
                    for (int i = 0; i < N; i++)
                        if (live[i] && state[i] == RS_EXPIRED)
                            final_slot = i;
                    if (final_slot < 0)
                        queue_result(ST_OK, 0, 1'b0, 1'b1);
                    for (int i = 0; i <= final_slot; i++) begin
                        if (live[i] && state[i] == RS_EXPIRED) begin
                            queue_result(ST_OK, i + 1, 1'b1, i == final_slot);
                            case (tmode[i])
                                MODE_ONE_DELETE: begin
                                    live[i]  = 1'b0;
                                    state[i] = RS_STOPPED;
                                end
                                MODE_LOOP: begin
                                    count[i] = '0;
                                    state[i] = RS_RUNNING;
                                end
                                MODE_ONE_KEEP: begin
                                    count[i] = '0;
                                    state[i] = RS_STOPPED;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: queue_result(ST_OK, 0, 1'b0, 1'b1);
            endcase
        endfunction

        function void match_result(t_timer_result got);
            t_timer_result want;
            if (due_results.size() == 0) begin
                fail($sformatf("unexpected result status=%0d id=%0d fired=%0d last=%0d",
                               got.status, got.slot_id, got.fired, got.last));
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.slot_id !== want.slot_id ||
                got.fired !== want.fired || got.last !== want.last)
                fail($sformatf({"expected status=%0d id=%0d fired=%0d last=%0d, ",
                                "got status=%0d id=%0d fired=%0d last=%0d"},
                               want.status, want.slot_id, want.fired, want.last,
                               got.status, got.slot_id, got.fired, got.last));
        endfunction

        function void flush_missing();
            t_timer_result want;
            while (due_results.size() != 0) begin
                want = due_results.pop_front();
                fail($sformatf("missing result status=%0d id=%0d fired=%0d last=%0d",
                               want.status, want.slot_id, want.fired, want.last));
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function int free_slots();
            int n;
            n = 0;
            for (int i = 0; i < N; i++)
                if (!live[i])
                    n++;
            return n;
        endfunction

        function int pick_live_id();
            int ids [$];
            for (int i = 0; i < N; i++)
                if (live[i])
                    ids.push_back(i + 1);
            if (ids.size() == 0)
                return $urandom_range(N, 1);
            return ids[$urandom_range(ids.size() - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mtt_in_if  in_ch ();
    mtt_out_if out_ch ();

    multi_timer_table #(.NUM_TIMERS(N)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    timer_table_board board = new();

    // idle percentages of the current phase
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: check each accepted transaction, then pick the next ready
    initial begin
        t_timer_result got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got.status  = out_ch.status;
                got.slot_id = out_ch.result_id;
                got.fired   = out_ch.fired;
                got.last    = out_ch.last;
                board.match_result(got);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one input transaction: optional idle gap, then hold valid until taken
    task automatic send_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [MODE_W-1:0] md, logic [CNT_W-1:0] per);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.timer_id  <= id;
        in_ch.mode      <= md;
        in_ch.period    <= per;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        board.note_op(op, id, md, per);
    endtask

    // sender pause until the block has handed over everything it owes
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (board.outstanding() != 0);
    endtask

    // mostly short periods so timers expire, now and then a full 32-bit one
    function automatic logic [CNT_W-1:0] random_period();
        int r;
        r = $urandom_range(9);
        if (r < 6)
            return CNT_W'($urandom_range(4));
        if (r < 9)
            return CNT_W'($urandom_range(24));
        return $urandom();
    endfunction

    // a live slot most of the time, an arbitrary identifier otherwise
    function automatic logic [ID_W-1:0] target_id();
        if ($urandom_range(9) == 0)
            return ID_W'($urandom_range(31));
        return ID_W'(board.pick_live_id());
    endfunction

    task automatic send_random_op();
        int              pick;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [MODE_W-1:0] md;
        logic [CNT_W-1:0] per;
        pick = $urandom_range(99);
        // fields an operation ignores still carry random bits
        id  = ID_W'($urandom_range(31));
        md  = MODE_W'($urandom_range(3));
        per = random_period();
        if (pick < 22) begin
            op = OP_CREATE;
        end else if (pick < 42) begin
            op = OP_START;
            id = target_id();
        end else if (pick < 50) begin
            op = OP_STOP;
            id = target_id();
        end else if (pick < 57) begin
            op = OP_DELETE;
            id = target_id();
        end else if (pick < 77) begin
            op = OP_TICK;
        end else if (pick < 92) begin
            op = OP_SERVICE;
        end else if (pick < 96) begin
            op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        end else begin
            // targeted operation with a raw identifier, often out of range
            case ($urandom_range(2))
                0:       op = OP_START;
                1:       op = OP_STOP;
                default: op = OP_DELETE;
            endcase
        end
        send_op(op, id, md, per);
    endtask

    // creates until the table overflows at least once
    task automatic fill_table();
        int n;
        n = board.free_slots() + 1;
        repeat (n)
            send_op(OP_CREATE, ID_W'($urandom_range(31)), MODE_W'($urandom_range(3)),
                    random_period());
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        set_idling(0, 0);
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_TICK;
        in_ch.timer_id  <= '0;
        in_ch.mode      <= MODE_ONE_DELETE;
        in_ch.period    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty service, identifier checks, each mode firing
        send_op(OP_SERVICE, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_START, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_STOP, 5'd17, MODE_ONE_DELETE, 32'd0);
        send_op(OP_DELETE, 5'd31, MODE_NONE, 32'hFFFF_FFFF);
        send_op(OP_START, 5'd1, MODE_ONE_DELETE, 32'd0);
        send_op(OP_CREATE, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_CREATE, 5'd0, MODE_LOOP, 32'd1);
        send_op(OP_CREATE, 5'd0, MODE_ONE_KEEP, 32'd2);
        send_op(OP_CREATE, 5'd0, MODE_NONE, 32'd0);
        for (int s = 1; s <= 4; s++)
            send_op(OP_START, ID_W'(s), MODE_ONE_DELETE, 32'd0);
        send_op(OP_TICK, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_SERVICE, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_TICK, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_SERVICE, 5'd0, MODE_ONE_DELETE, 32'd0);
        // restart of an expired timer keeps its count, so it expires again
        send_op(OP_START, 5'd4, MODE_ONE_DELETE, 32'd0);
        send_op(OP_TICK, 5'd0, MODE_ONE_DELETE, 32'd0);
        send_op(OP_STOP, 5'd4, MODE_ONE_DELETE, 32'd0);
        send_op(OP_DELETE, 5'd2, MODE_ONE_DELETE, 32'd0);
        send_op(OP_DELETE, 5'd2, MODE_ONE_DELETE, 32'd0);
        send_op(OP_SPARE_A, 5'd31, MODE_NONE, 32'hFFFF_FFFF);
        send_op(OP_SPARE_B, 5'd16, MODE_LOOP, 32'h5555_AAAA);
        send_op(OP_CREATE, 5'd0, MODE_LOOP, 32'hFFFF_FFFF);
        wait_for_results();

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(80, 0);
                2:       set_idling(0, 80);
                default: set_idling(16, 16);
            endcase
            for (int k = 0; k < PHASE_OPS; k++) begin
                if (k == PHASE_OPS / 2 && (ph == 0 || ph == 3))
                    fill_table();
                send_random_op();
            end
            wait_for_results();
        end

        // let any stray transaction show up before the verdict
        repeat (SETTLE) @(posedge i_clk);
        board.flush_missing();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
